// ===== src/tksd_pkg.sv =====
`default_nettype none

package tksd_pkg;

    // Character codes used by the decoder.
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;

    // Key codes.
    localparam logic [7:0] KEY_BASE    = 8'h80;
    localparam logic [7:0] KEY_UNKNOWN = 8'hFF;
    localparam logic [7:0] CODE_ESCAPE = 8'h1B;

    // Key table geometry.
    localparam int KEY_COUNT  = 23;
    localparam int FKEY_FIRST = 11;
    localparam int FKEY_NUM   = 5;
    localparam int MATCH_MAX  = 3;

    localparam logic [1:0] KEY_LEN [KEY_COUNT] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };

    localparam logic [7:0] KEY_SEQ [KEY_COUNT][MATCH_MAX] = '{
        '{"B", 8'h00, 8'h00}, '{"A", 8'h00, 8'h00},
        '{"D", 8'h00, 8'h00}, '{"C", 8'h00, 8'h00},
        '{"1", "~", 8'h00}, '{"3", "~", 8'h00}, '{"2", "~", 8'h00},
        '{"6", "~", 8'h00}, '{"5", "~", 8'h00}, '{"4", "~", 8'h00},
        '{"Z", 8'h00, 8'h00},
        '{"1", "1", "~"}, '{"1", "2", "~"}, '{"1", "3", "~"},
        '{"1", "4", "~"}, '{"1", "5", "~"},
        '{"1", "7", "~"}, '{"1", "8", "~"}, '{"1", "9", "~"},
        '{"2", "0", "~"}, '{"2", "1", "~"}, '{"2", "3", "~"},
        '{"2", "4", "~"}
    };

    // Linux console F1..F5: two bytes each.
    localparam logic [7:0] LINUX_FKEY [FKEY_NUM][2] = '{
        '{"[", "A"}, '{"[", "B"}, '{"[", "C"}, '{"[", "D"}, '{"[", "E"}
    };

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_SEQ  = 2'd2
    } phase_t;

    // Request to the key table matcher.
    typedef struct packed {
        logic       too_long;
        logic [1:0] seq_len;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] last;
        logic       linux_style;
    } tksd_match_req_t;

    // Result of one decode step.
    typedef struct packed {
        logic       emit;
        logic [7:0] code;
    } tksd_result_t;

endpackage

`default_nettype wire

// ===== src/tksd_rx_if.sv =====
`default_nettype none

interface tksd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/tksd_key_if.sv =====
`default_nettype none

interface tksd_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

`default_nettype wire

// ===== src/tksd_cfg_if.sv =====
`default_nettype none

interface tksd_cfg_if;
    logic valid;
    logic ready;
    logic function_key_style;

    modport source (output valid, output function_key_style, input ready);
    modport sink   (input valid, input function_key_style, output ready);
endinterface

`default_nettype wire

// ===== src/tksd_match.sv =====
`default_nettype none

module tksd_match
    import tksd_pkg::*;
(
    input  tksd_match_req_t req,
    output logic [7:0]      key_code
);

    logic [1:0]          ent_len [KEY_COUNT];
    logic [7:0]          ent_seq [KEY_COUNT][MATCH_MAX];
    logic [KEY_COUNT-1:0] hit;

    // Every table entry is compared in parallel.
    always_comb
    begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (req.linux_style && i >= FKEY_FIRST && i < FKEY_FIRST + FKEY_NUM)
            begin
                ent_len[i]    = 2'd2;
                ent_seq[i][0] = LINUX_FKEY[i - FKEY_FIRST][0];
                ent_seq[i][1] = LINUX_FKEY[i - FKEY_FIRST][1];
                ent_seq[i][2] = 8'h00;
            end
            else
            begin
                ent_len[i]    = KEY_LEN[i];
                ent_seq[i][0] = KEY_SEQ[i][0];
                ent_seq[i][1] = KEY_SEQ[i][1];
                ent_seq[i][2] = KEY_SEQ[i][2];
            end

            if (req.too_long || ent_len[i] != req.seq_len)
            begin
                hit[i] = 1'b0;
            end
            else
            begin
                unique case (req.seq_len)
                    2'd1:    hit[i] = (req.last == ent_seq[i][0]);
                    2'd2:    hit[i] = (req.byte0 == ent_seq[i][0]) &&
                                      (req.last == ent_seq[i][1]);
                    2'd3:    hit[i] = (req.byte0 == ent_seq[i][0]) &&
                                      (req.byte1 == ent_seq[i][1]) &&
                                      (req.last == ent_seq[i][2]);
                    default: hit[i] = 1'b0;
                endcase
            end
        end
    end

    // The lowest matching index wins.
    always_comb
    begin
        key_code = KEY_UNKNOWN;
        for (int i = KEY_COUNT - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                key_code = KEY_BASE + 8'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tksd_decoder.sv =====
`default_nettype none

module tksd_decoder
    import tksd_pkg::*;
#(
    parameter int SEQ_MAX = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   in_byte,
    input  logic         linux_style,
    output tksd_result_t res
);

    localparam int CNT_W = $clog2(SEQ_MAX);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [7:0]         seq_bytes_reg [2];
    logic               store_en;
    logic               term;
    tksd_match_req_t    match_req;
    logic [7:0]         match_code;

    assign term = ((in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z)) ||
                  (in_byte == CH_TILDE);

    // Only the first two collected bytes can ever take part in a match.
    assign match_req.too_long    = (cnt_reg > CNT_W'(2));
    assign match_req.seq_len     = cnt_reg[1:0] + 2'd1;
    assign match_req.byte0       = seq_bytes_reg[0];
    assign match_req.byte1       = seq_bytes_reg[1];
    assign match_req.last        = in_byte;
    assign match_req.linux_style = linux_style;

    tksd_match u_match
    (
        .req      (match_req),
        .key_code (match_code)
    );

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        store_en   = 1'b0;
        res.emit   = 1'b0;
        res.code   = in_byte;
        unique case (phase_reg)
            PH_ESC:
            begin
                if (in_byte == CH_ESC)
                begin
                    phase_next = PH_IDLE;
                    res.emit   = 1'b1;
                    res.code   = CODE_ESCAPE;
                end
                else if (in_byte == CH_LBRACKET)
                begin
                    phase_next = PH_SEQ;
                    cnt_next   = '0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    res.emit   = 1'b1;
                    res.code   = KEY_UNKNOWN;
                end
            end
            PH_SEQ:
            begin
                if (term || cnt_reg == CNT_W'(SEQ_MAX - 1))
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                    res.emit   = 1'b1;
                    res.code   = match_code;
                end
                else
                begin
                    store_en = (cnt_reg < CNT_W'(2));
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                if (in_byte == CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    res.emit   = 1'b1;
                    res.code   = (in_byte == CH_DEL) ? CH_BS : in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && store_en)
        begin
            seq_bytes_reg[cnt_reg[0]] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/terminal_key_sequence_decoder.sv =====
// Terminal key sequence decoder: received terminal bytes enter on rx and decoded
// key codes leave on key, one transaction per cycle when neither side stalls.
// Plain bytes pass through (DEL becomes backspace 0x08), ESC ESC gives 0x1B,
// ESC followed by anything but ESC or '[' gives 0xFF, and ESC '[' sequences of up to
// SEQ_MAX bytes are matched against a 23-entry key table to give 0x80 plus the
// entry index, or 0xFF when nothing matches. Bytes that open or continue a
// sequence give no output transaction. The block accepts one byte every cycle
// while the output is not stalled; a result passes through the input
// register and then through the decode logic into the output register, with
// the whole table compared in parallel. The cfg channel writes the function key
// style bit (0 VT400 "11~".."15~", 1 Linux console "[A".."[E"); it is always
// ready and should be written only while no bytes are in flight.
`default_nettype none

module terminal_key_sequence_decoder
    import tksd_pkg::*;
#(
    parameter int SEQ_MAX = 3
)
(
    input  logic      clk,
    input  logic      rst_n,
    tksd_rx_if.sink   rx,
    tksd_key_if.source key,
    tksd_cfg_if.sink  cfg
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    logic [7:0]   out_code_reg;
    logic         style_reg;
    logic         advance;
    logic         step;
    tksd_result_t res;

    // The output register can take a new result when it is empty or being
    // drained in this cycle. The input register moves on under the same rule,
    // so a full output register that is stalled holds one more byte in the
    // input register before rx is throttled.
    assign advance  = !out_valid_reg || key.ready;
    assign step     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;

    assign key.valid    = out_valid_reg;
    assign key.key_code = out_code_reg;
    assign cfg.ready    = 1'b1;

    tksd_decoder #(
        .SEQ_MAX (SEQ_MAX)
    ) u_decoder
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .in_byte     (in_byte_reg),
        .linux_style (style_reg),
        .res         (res)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            style_reg     <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            // A byte that produces no key code leaves the output empty.
            if (advance)
            begin
                out_valid_reg <= step && res.emit;
            end

            if (cfg.valid && cfg.ready)
            begin
                style_reg <= cfg.function_key_style;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (step && res.emit)
        begin
            out_code_reg <= res.code;
        end
    end

endmodule

`default_nettype wire

// ===== src/tksd_checker.sv =====
`default_nettype none

module tksd_checker
(
    input  logic       clk,
    input  logic       rst_n,
    tksd_rx_if.sink    rx,
    tksd_key_if.source key,
    tksd_cfg_if.sink   cfg
);

    // A stalled key transaction keeps its code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (key.valid && !key.ready) |=> (key.valid && $stable(key.key_code)))
        else $error("key code changed while stalled");

    // DEL is always turned into backspace, and nothing else yields 0x7F.
    assert property (@(posedge clk) disable iff (!rst_n)
        key.valid |-> (key.key_code != 8'h7F))
        else $error("key code 0x7F delivered");

    // Every new key code follows an accepted byte that caused it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key.valid) |-> $past(rx.valid && rx.ready, 2))
        else $error("key code without a matching received byte");

    // With the output stalled, at most one more byte is taken in.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready && key.valid && !key.ready)
        |=> (!(key.valid && !key.ready) || !rx.ready))
        else $error("input not throttled behind a stalled output");

    // Configuration writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |-> cfg.ready)
        else $error("configuration write refused");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .rx    (rx),
    .key   (key),
    .cfg   (cfg)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tksd_pkg::*;

    // Sequence length limit (SEQ_MAX) of the decoder under test.
    localparam int SEQ_LIMIT = 3;

    // Cycles to let pass after the last expected key before the block counts as idle.
    localparam int DRAIN_CYCLES = 6;

    // The run is ended when no transaction moves on any channel for this long.
    localparam int STALL_LIMIT = 5000;

    // Chance, in percent, that a side idles in a given cycle.
    localparam int IDLE_PERCENT = 34;

    logic clk;
    logic rst_n;

    tksd_rx_if  rx_if ();
    tksd_key_if key_if ();
    tksd_cfg_if cfg_if ();

    terminal_key_sequence_decoder #(
        .SEQ_MAX (SEQ_LIMIT)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .key   (key_if),
        .cfg   (cfg_if)
    );

    // The key patterns that follow ESC '[', in key code order. Codes start at
    // 0x80 with down, up, left, right, then the editing keys, back tab and the
    // function keys F1 to F12.
    string vt_keys [KEY_COUNT] = '{
        "B", "A", "D", "C",
        "1~", "3~", "2~", "6~", "5~", "4~",
        "Z",
        "11~", "12~", "13~", "14~", "15~",
        "17~", "18~", "19~", "20~", "21~", "23~", "24~"
    };

    // With the Linux console style selected, F1 to F5 use these instead.
    string linux_keys [FKEY_NUM] = '{"[A", "[B", "[C", "[D", "[E"};

    // Predicted decoder state. It mirrors what the block holds between bytes.
    phase_t     rx_phase;
    int         seq_len;
    logic [7:0] seq_held [SEQ_LIMIT-1];
    bit         fkey_style;

    // Key codes that are predicted but have not come out yet, oldest first.
    logic [7:0] key_expected [$];

    int  error_count;
    int  stall_cycles;
    bit  gaps_on;
    int  rx_sent;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Looks up the collected sequence, closed by the byte in last, in the key
    // list. Only a pattern with the same length and the same bytes matches,
    // and the first one that matches decides the code.
    function automatic logic [7:0] match_key_list(input logic [7:0] last);
        int    n;
        string pat;
        bit    hit;
        n = seq_len + 1;
        if (n > MATCH_MAX)
            return KEY_UNKNOWN;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (fkey_style && i >= FKEY_FIRST && i < FKEY_FIRST + FKEY_NUM)
                pat = linux_keys[i - FKEY_FIRST];
            else
                pat = vt_keys[i];
            if (pat.len() == n)
            begin
                hit = (pat[n-1] == last);
                for (int k = 0; k < n - 1; k++)
                begin
                    if (pat[k] != seq_held[k])
                        hit = 1'b0;
                end
                if (hit)
                    return KEY_BASE + 8'(i);
            end
        end
        return KEY_UNKNOWN;
    endfunction

    // Advances the predicted state by one accepted byte and queues the key
    // code that the byte gives, if it gives one.
    function automatic void decode_rx_byte(input logic [7:0] b);
        bit term;
        case (rx_phase)
            PH_ESC:
            begin
                if (b == CH_ESC)
                begin
                    rx_phase = PH_IDLE;
                    key_expected.push_back(CODE_ESCAPE);
                end
                else if (b == CH_LBRACKET)
                begin
                    rx_phase = PH_SEQ;
                    seq_len = 0;
                end
                else
                begin
                    // Any other byte after ESC is swallowed and reported as unknown.
                    rx_phase = PH_IDLE;
                    key_expected.push_back(KEY_UNKNOWN);
                end
            end
            PH_SEQ:
            begin
                term = (b >= CH_UPPER_A && b <= CH_UPPER_Z) || b == CH_TILDE;
                if (!term && seq_len + 1 < SEQ_LIMIT)
                begin
                    seq_held[seq_len] = b;
                    seq_len++;
                end
                else
                begin
                    // A terminator, or a full buffer, closes the sequence.
                    key_expected.push_back(match_key_list(b));
                    rx_phase = PH_IDLE;
                    seq_len = 0;
                end
            end
            default:
            begin
                rx_phase = PH_IDLE;
                if (b == CH_ESC)
                    rx_phase = PH_ESC;
                else
                    key_expected.push_back((b == CH_DEL) ? CH_BS : b);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Any cycle in which a transaction moves on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_if.valid && rx_if.ready) || (key_if.valid && key_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Key output side: random back-pressure and the result check
    // ------------------------------------------------------------------

    initial
    begin
        key_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                key_if.ready = 1'b0;
            else if (gaps_on)
                key_if.ready = ($urandom_range(99) >= IDLE_PERCENT);
            else
                key_if.ready = 1'b1;
        end
    end

    // Every key transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && key_if.valid && key_if.ready)
        begin
            if (key_expected.size() == 0)
            begin
                $display("%0t: key_code expected none, got %h", $time, key_if.key_code);
                error_count++;
            end
            else
            begin
                if (key_if.key_code !== key_expected[0])
                begin
                    $display("%0t: key_code expected %h, got %h",
                             $time, key_expected[0], key_if.key_code);
                    error_count++;
                end
                void'(key_expected.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offers one byte on the receive channel, after random idle cycles when
    // gaps are enabled, and returns at the edge where it is accepted. The
    // valid line stays high so that back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            @(negedge clk);
            rx_if.valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        decode_rx_byte(b);
    endtask

    // Sends ESC '[' followed by the bytes of one pattern.
    task automatic send_key_sequence(input string pat);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        for (int k = 0; k < pat.len(); k++)
            send_byte(pat[k]);
    endtask

    // Stops offering bytes and waits until every predicted key has come out,
    // then lets the block settle, since a byte in the middle of a sequence
    // can still be on its way when the last key appears.
    task automatic drain_keys();
        @(negedge clk);
        rx_if.valid = 1'b0;
        while (key_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the function key style bit while the block is idle.
    task automatic write_fkey_style(input bit style);
        drain_keys();
        @(negedge clk);
        cfg_if.valid              = 1'b1;
        cfg_if.function_key_style = style;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        fkey_style = style;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain bytes pass through, at both ends of the range, and DEL turns into
    // backspace.
    task automatic test_plain_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_DEL);
        send_byte(CH_BS);
        send_byte(8'h80);
        send_byte(CH_LBRACKET);
        send_byte(CH_TILDE);
    endtask

    // A double ESC gives the escape key, and ESC followed by anything other
    // than '[' gives the unknown key with that byte dropped.
    task automatic test_escape_pairs();
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(8'h71);
        send_byte(CH_ESC);
        send_byte(8'h00);
    endtask

    // Sequences in the VT400 style: short and long keys, a Linux console
    // pattern that is unknown in this style, a sequence that runs out of room
    // without a terminator, a zero byte inside a sequence, and a lone '~'.
    task automatic test_vt400_sequences();
        send_key_sequence("A");
        send_key_sequence("11~");
        send_key_sequence("24~");
        send_key_sequence("[A");
        send_key_sequence("123");
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        send_byte(8'h00);
        send_byte(CH_TILDE);
        send_key_sequence("~");
    endtask

    // With the Linux console style, F1 to F5 are '[' plus a letter, and the
    // VT400 function key patterns are no longer recognized.
    task automatic test_linux_sequences();
        write_fkey_style(1'b1);
        send_key_sequence("[A");
        send_key_sequence("[E");
        send_key_sequence("11~");
        send_key_sequence("4~");
    endtask

    // Picks a byte that is likely to matter inside a sequence.
    function automatic logic [7:0] pick_seq_byte();
        case ($urandom_range(5))
            0: return 8'h30 + 8'($urandom_range(9));
            1: return CH_TILDE;
            2: return CH_UPPER_A + 8'($urandom_range(25));
            3: return CH_LBRACKET;
            4: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random traffic: mostly well-formed key sequences of either style, with
    // escape pairs, broken sequences and plain bytes mixed in. Runs until the
    // given number of bytes has been accepted.
    task automatic test_random_traffic(input int byte_count, input bit style,
                                       input bit gaps);
        int    sent_before;
        int    kind;
        int    idx;
        int    tail;
        string pat;
        write_fkey_style(style);
        gaps_on = gaps;
        sent_before = rx_sent;
        while (rx_sent - sent_before < byte_count)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                idx = $urandom_range(KEY_COUNT - 1);
                if (idx >= FKEY_FIRST && idx < FKEY_FIRST + FKEY_NUM && $urandom_range(1))
                    pat = linux_keys[idx - FKEY_FIRST];
                else
                    pat = vt_keys[idx];
                send_key_sequence(pat);
                rx_sent += pat.len() + 2;
            end
            else if (kind < 63)
            begin
                send_byte(CH_ESC);
                send_byte(CH_ESC);
                rx_sent += 2;
            end
            else if (kind < 70)
            begin
                send_byte(CH_ESC);
                send_byte(8'($urandom));
                rx_sent += 2;
            end
            else if (kind < 82)
            begin
                // A sequence with random content, possibly too long.
                send_byte(CH_ESC);
                send_byte(CH_LBRACKET);
                tail = $urandom_range(1, 4);
                for (int k = 0; k < tail; k++)
                    send_byte(pick_seq_byte());
                rx_sent += tail + 2;
            end
            else
            begin
                send_byte(($urandom_range(9) == 0) ? CH_DEL : 8'($urandom));
                rx_sent += 1;
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n                     = 1'b0;
        rx_if.valid               = 1'b0;
        rx_if.rx_byte             = 8'h00;
        cfg_if.valid              = 1'b0;
        cfg_if.function_key_style = 1'b0;
        rx_phase                  = PH_IDLE;
        seq_len                   = 0;
        seq_held                  = '{default: 8'h00};
        fkey_style                = 1'b0;
        error_count               = 0;
        stall_cycles              = 0;
        gaps_on                   = 1'b1;
        rx_sent                   = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The style register starts in the VT400 setting after reset.
        test_plain_bytes();
        test_escape_pairs();
        test_vt400_sequences();
        test_linux_sequences();

        test_random_traffic(130, 1'b0, 1'b1);
        test_random_traffic(90, 1'b1, 1'b0);
        test_random_traffic(90, 1'b1, 1'b1);
        test_random_traffic(90, 1'b0, 1'b1);

        drain_keys();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
